>>> rtl/compressed_unicode_to_utf8_top_assert.svh
// assertion macros used by the cu8 back end
`ifndef COMPRESSED_UNICODE_TO_UTF8_TOP_ASSERT_SVH
`define COMPRESSED_UNICODE_TO_UTF8_TOP_ASSERT_SVH

// clocked check, masked while reset is held
`define CU8_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds during reset
`define CU8_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/cu8_pkg.sv
// shared types and constants of the compressed unicode to utf-8 decoder
`timescale 1ns / 1ps
`default_nettype none
package cu8_pkg;

    // compression mode of the open string
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_8    = 2'd1;
    localparam logic [1:0] MODE_16   = 2'd2;
    localparam logic [1:0] MODE_BAD  = 2'd3;

    // final status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_ID = 2'd1;
    localparam logic [1:0] ST_ODD    = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

    // compression ids
    localparam logic [7:0] ID_8  = 8'd8;
    localparam logic [7:0] ID_16 = 8'd16;

    // utf-8 length limits
    localparam logic [15:0] LIMIT_1B = 16'h0080;
    localparam logic [15:0] LIMIT_2B = 16'h0800;

    // utf-8 byte prefixes
    localparam logic [2:0] LEAD_2B = 3'b110;
    localparam logic [3:0] LEAD_3B = 4'b1110;
    localparam logic [1:0] CONT_B  = 2'b10;

    localparam logic [15:0] CAP_RESET = 16'd256;
    localparam int          JOB_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_end;
        logic [1:0]  status;
        logic [15:0] out_length;
    } out_item_t;

    // one decoded unit plus optional terminator, handed from front to back
    typedef struct packed {
        logic [15:0] unit;
        logic [1:0]  nbytes;
        logic        is_end;
        logic [1:0]  status;
        logic [15:0] length;
    } job_t;

endpackage
`default_nettype wire

>>> rtl/cu8_front.sv
// front end: accepts input bytes, tracks string state, builds jobs
`timescale 1ns / 1ps
`default_nettype none
module cu8_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  cu8_pkg::in_item_t      s_data,
    input  wire logic [15:0]       out_capacity,
    output logic                   push,
    output cu8_pkg::job_t          push_job,
    input  wire logic              job_full
);

    logic [1:0]  mode_reg, mode_next;
    logic        hp_reg, hp_next;
    logic [7:0]  hb_reg, hb_next;
    logic [15:0] bc_reg, bc_next;
    logic        stop_reg, stop_next;
    logic [1:0]  err_reg, err_next;

    logic        acc;
    logic        opened;
    logic        have;
    logic [15:0] unit;
    logic [1:0]  nb;
    logic [1:0]  nb_emit;
    logic [16:0] bc_sum;
    logic [1:0]  st;

    assign s_ready = !job_full;
    assign acc     = s_valid && s_ready;

    // utf-8 length of the current unit
    always_comb begin
        if (unit < cu8_pkg::LIMIT_1B) begin
            nb = 2'd1;
        end else if (unit < cu8_pkg::LIMIT_2B) begin
            nb = 2'd2;
        end else begin
            nb = 2'd3;
        end
    end

    assign bc_sum = {1'b0, bc_reg} + {15'd0, nb};

    always_comb begin
        mode_next = mode_reg;
        hp_next   = hp_reg;
        hb_next   = hb_reg;
        bc_next   = bc_reg;
        stop_next = stop_reg;
        err_next  = err_reg;
        opened    = 1'b0;
        have      = 1'b0;
        unit      = '0;
        nb_emit   = 2'd0;
        st        = cu8_pkg::ST_OK;
        push      = 1'b0;
        if (acc) begin
            if (s_data.first_byte) begin
                opened  = 1'b1;
                hp_next = 1'b0;
                hb_next = '0;
                bc_next = '0;
                if (s_data.in_byte == cu8_pkg::ID_8) begin
                    mode_next = cu8_pkg::MODE_8;
                    stop_next = 1'b0;
                    err_next  = cu8_pkg::ST_OK;
                end else if (s_data.in_byte == cu8_pkg::ID_16) begin
                    mode_next = cu8_pkg::MODE_16;
                    stop_next = 1'b0;
                    err_next  = cu8_pkg::ST_OK;
                end else begin
                    mode_next = cu8_pkg::MODE_BAD;
                    stop_next = 1'b1;
                    err_next  = cu8_pkg::ST_BAD_ID;
                end
            end else if (mode_reg != cu8_pkg::MODE_NONE) begin
                opened = 1'b1;
                case (mode_reg)
                    cu8_pkg::MODE_8: begin
                        unit = {8'd0, s_data.in_byte};
                        have = 1'b1;
                    end
                    cu8_pkg::MODE_16: begin
                        if (!hp_reg) begin
                            hb_next = s_data.in_byte;
                            hp_next = 1'b1;
                        end else begin
                            unit    = {hb_reg, s_data.in_byte};
                            hp_next = 1'b0;
                            have    = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (have && !stop_reg) begin
                    if (unit == 16'd0) begin
                        stop_next = 1'b1;
                    end else if (bc_sum >= {1'b0, out_capacity}) begin
                        stop_next = 1'b1;
                        err_next  = cu8_pkg::ST_OVF;
                    end else begin
                        nb_emit = nb;
                        bc_next = bc_sum[15:0];
                    end
                end
            end
            if (opened && s_data.last_byte) begin
                if (out_capacity == 16'd0) begin
                    st = cu8_pkg::ST_OVF;
                end else if (mode_next == cu8_pkg::MODE_BAD) begin
                    st = cu8_pkg::ST_BAD_ID;
                end else if (mode_next == cu8_pkg::MODE_16 && hp_next) begin
                    st = cu8_pkg::ST_ODD;
                end else begin
                    st = err_next;
                end
            end
            push = opened && (nb_emit != 2'd0 || s_data.last_byte);
        end
    end

    always_comb begin
        push_job.unit   = unit;
        push_job.nbytes = nb_emit;
        push_job.is_end = s_data.last_byte;
        push_job.status = st;
        push_job.length = bc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cu8_pkg::MODE_NONE;
            hp_reg   <= 1'b0;
            hb_reg   <= '0;
            bc_reg   <= '0;
            stop_reg <= 1'b0;
            err_reg  <= cu8_pkg::ST_OK;
        end else if (opened && s_data.last_byte) begin
            mode_reg <= cu8_pkg::MODE_NONE;
            hp_reg   <= 1'b0;
            hb_reg   <= '0;
            bc_reg   <= '0;
            stop_reg <= 1'b0;
            err_reg  <= cu8_pkg::ST_OK;
        end else begin
            mode_reg <= mode_next;
            hp_reg   <= hp_next;
            hb_reg   <= hb_next;
            bc_reg   <= bc_next;
            stop_reg <= stop_next;
            err_reg  <= err_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/cu8_job_fifo.sv
// small job queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module cu8_job_fifo #(
    parameter int DEPTH = cu8_pkg::JOB_DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  cu8_pkg::job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output cu8_pkg::job_t pop_job,
    output logic          not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cu8_pkg::job_t    entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

>>> rtl/cu8_back.sv
// back end: expands jobs into utf-8 bytes and the terminator
`timescale 1ns / 1ps
`default_nettype none
`include "compressed_unicode_to_utf8_top_assert.svh"
module cu8_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  cu8_pkg::job_t      job,
    input  wire logic          job_avail,
    output logic               job_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cu8_pkg::out_item_t m_data
);

    logic               busy_reg, busy_next;
    cu8_pkg::job_t      job_reg, job_next;
    logic [1:0]         pos_reg, pos_next;
    logic               m_valid_reg, m_valid_next;
    cu8_pkg::out_item_t m_data_reg, m_data_next;

    logic               can_emit;
    logic               last_piece;
    logic [2:0]         total;
    cu8_pkg::out_item_t piece;

    assign total      = {1'b0, job_reg.nbytes} + {2'd0, job_reg.is_end};
    assign last_piece = ({1'b0, pos_reg} + 3'd1) == total;
    assign can_emit   = busy_reg && (!m_valid_reg || m_ready);
    assign job_pop    = job_avail && (!busy_reg || (can_emit && last_piece));

    // byte or terminator selected by the current position
    always_comb begin
        piece.out_byte   = 8'd0;
        piece.is_end     = 1'b0;
        piece.status     = cu8_pkg::ST_OK;
        piece.out_length = '0;
        if (pos_reg < job_reg.nbytes) begin
            case (job_reg.nbytes)
                2'd1: piece.out_byte = job_reg.unit[7:0];
                2'd2: begin
                    if (pos_reg == 2'd0) begin
                        piece.out_byte = {cu8_pkg::LEAD_2B, job_reg.unit[10:6]};
                    end else begin
                        piece.out_byte = {cu8_pkg::CONT_B, job_reg.unit[5:0]};
                    end
                end
                2'd3: begin
                    case (pos_reg)
                        2'd0: piece.out_byte = {cu8_pkg::LEAD_3B, job_reg.unit[15:12]};
                        2'd1: piece.out_byte = {cu8_pkg::CONT_B, job_reg.unit[11:6]};
                        default: piece.out_byte = {cu8_pkg::CONT_B, job_reg.unit[5:0]};
                    endcase
                end
                default: piece.out_byte = 8'd0;
            endcase
        end else begin
            piece.is_end     = 1'b1;
            piece.status     = job_reg.status;
            piece.out_length = job_reg.length;
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        job_next     = job_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (can_emit) begin
            m_valid_next = 1'b1;
            m_data_next  = piece;
            pos_next     = pos_reg + 1'b1;
            if (last_piece) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (job_pop) begin
            busy_next = 1'b1;
            job_next  = job;
            pos_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pos_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CU8_ASSERT_RST(a_data_fields_zero, m_valid_reg && !m_data_reg.is_end |-> m_data_reg.status == cu8_pkg::ST_OK && m_data_reg.out_length == 16'd0, "data byte carries status or length")
    `CU8_ASSERT_RST(a_term_zero_byte, m_valid_reg && m_data_reg.is_end |-> m_data_reg.out_byte == 8'd0, "terminator byte not zero")
    `CU8_ASSERT_RST(a_pos_in_range, busy_reg |-> {1'b0, pos_reg} < total, "piece position past end of job")
    `CU8_ASSERT_ALL(a_reset_idle, !aresetn |=> !busy_reg && !m_valid_reg, "back end not idle after reset")

endmodule
`default_nettype wire

>>> rtl/compressed_unicode_to_utf8_top.sv
// top level of the compressed unicode to utf-8 stream decoder
//
//  channel   dir  handshake             payload
//  s_        in   s_valid / s_ready     s_data  (in_byte, first_byte, last_byte)
//  m_        out  m_valid / m_ready     m_data  (out_byte, is_end, status, out_length)
//  cfg_      in   cfg_wr_en             cfg_wr_data (out_capacity)
//
//  the front takes one input byte per cycle while the job queue has room
//  each accepted byte yields 0 to 4 output transactions (up to three utf-8
//  bytes plus the terminator); the back sends one transaction per cycle while
//  the output register is empty or m_ready is high
//  reset is synchronous, active low: string state and queue clear, capacity = 256
//  output stalls back up through the queue to s_ready; the input side is
//  held only while the job queue is full
`timescale 1ns / 1ps
`default_nettype none
module compressed_unicode_to_utf8_top #(
    parameter int JOB_DEPTH = cu8_pkg::JOB_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // input byte stream
    input  wire logic          s_valid,
    output logic               s_ready,
    input  cu8_pkg::in_item_t  s_data,
    // utf-8 result stream
    output logic               m_valid,
    input  wire logic          m_ready,
    output cu8_pkg::out_item_t m_data,
    // capacity register write
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data
);

    // output buffer size, terminator included
    logic [15:0]   cap_reg;

    // front to queue
    logic          push;
    cu8_pkg::job_t push_job;
    logic          job_full;

    // queue to back
    logic          pop;
    cu8_pkg::job_t pop_job;
    logic          job_avail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= cu8_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // classify bytes, run the string state, decide what each byte emits
    cu8_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .out_capacity (cap_reg),
        .push         (push),
        .push_job     (push_job),
        .job_full     (job_full)
    );

    // decouples the byte rate of the front from the expansion in the back
    cu8_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (job_full),
        .pop       (pop),
        .pop_job   (pop_job),
        .not_empty (job_avail)
    );

    // one utf-8 byte or terminator per cycle into the output register, while it is empty or m_ready is high
    cu8_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (pop_job),
        .job_avail (job_avail),
        .job_pop   (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
